// ----- rtl/eotq_pkg.sv -----
package eotq_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 32;
   localparam int DATA_W = 32;

   // Operation codes of a request.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // Status codes of a result.
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DELETED  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FIRED    = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   // Register index of the scan interval (byte address bit 2).
   localparam logic       CSR_CHECK_INTERVAL = 1'b0;
   localparam logic [31:0] CHECK_INTERVAL_RESET = 32'd100000;

   localparam logic [ID_W-1:0]   ID_MAX   = '1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [1:0]        op;
      logic [TIME_W-1:0] now;
      logic [31:0]       delay;
      logic [DATA_W-1:0] in_payload;
      logic [ID_W-1:0]   del_id;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ID_W-1:0]   out_id;
      logic [DATA_W-1:0] out_payload;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic            ins;
      logic            del;
      logic            pop;
      entry_type       new_ent;
      logic [ID_W-1:0] del_id;
   } cell_cmd_type;

endpackage

// ----- rtl/eotq_cell.sv -----
module eotq_cell #(
   parameter int SLOT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eotq_pkg::cell_cmd_type cmd,
   input  logic [SLOT_W-1:0]      new_slot,
   input  eotq_pkg::entry_type    left_ent,
   input  logic [SLOT_W-1:0]      left_slot,
   input  logic                   left_lt,
   input  logic                   left_hit,
   input  eotq_pkg::entry_type    right_ent,
   input  logic [SLOT_W-1:0]      right_slot,
   output eotq_pkg::entry_type    ent,
   output logic [SLOT_W-1:0]      slot,
   output logic                   lt,
   output logic                   hit,
   output logic [SLOT_W-1:0]      del_slot
);

   eotq_pkg::entry_type ent_ff, ent_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                match;

   // The new entry sorts ahead of this one: earlier expiry, then smaller id,
   // then lower slot number. An empty cell is always behind.
   always_comb begin
      lt = !ent_ff.valid
         || (cmd.new_ent.expiry < ent_ff.expiry)
         || ((cmd.new_ent.expiry == ent_ff.expiry) && (cmd.new_ent.id < ent_ff.id))
         || ((cmd.new_ent.expiry == ent_ff.expiry) && (cmd.new_ent.id == ent_ff.id)
             && (new_slot < slot_ff));
   end

   // The first matching cell along the row is the one with the earliest
   // expiry, since the row is kept sorted.
   assign match    = ent_ff.valid && (ent_ff.id == cmd.del_id);
   assign hit      = left_hit || match;
   assign del_slot = (match && !left_hit) ? slot_ff : '0;

   always_comb begin
      ent_in  = ent_ff;
      slot_in = slot_ff;
      if (cmd.ins) begin
         if (lt && !left_lt) begin
            ent_in  = cmd.new_ent;
            slot_in = new_slot;
         end else if (lt) begin
            ent_in  = left_ent;
            slot_in = left_slot;
         end
      end else if (cmd.pop || (cmd.del && hit)) begin
         ent_in  = right_ent;
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.expiry  <= ent_in.expiry;
      ent_ff.id      <= ent_in.id;
      ent_ff.payload <= ent_in.payload;
      slot_ff        <= slot_in;
   end

   assign ent  = ent_ff;
   assign slot = slot_ff;

endmodule

// ----- rtl/expiry_ordered_timer_queue_top.sv -----
// Timer queue with add, delete and tick requests.
// Requests enter on req_valid/req_stall, one at a time; results leave on
// rsp_valid/rsp_stall from an output register, so the next request is taken
// while a result still waits. Timers live in a row of cells kept sorted by
// expiry, then id, then slot number; every cell shifts to a neighbor in the
// same cycle, so an insert, a removal or a pop moves the whole row at once.
// An add, delete or tick request passes through S_PREP, then S_ADD, S_DEL or
// S_TICK, which loads its result; a tick gives one result per fired timer
// (1 to DEPTH results), or one when nothing fires. The request side is stalled
// until the last result of a request is in the output register; a stalled
// output holds the row still, so the tick pace follows the receiver.
// The register check_interval sits at byte address 0 of the csr_ port and
// must be written only while the block is idle.
// Reset (synchronous, active high) empties the table at once, sets the next
// id to 1, the last check time to 0 and check_interval to 100000; the block
// takes requests as soon as reset is released.
module expiry_ordered_timer_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eotq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eotq_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int SLOT_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_ADD  = 5'b00100,
      S_DEL  = 5'b01000,
      S_TICK = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   eotq_pkg::req_type               req_ff;
   logic [eotq_pkg::TIME_W-1:0]     exp_ff;
   logic                            due_ff;
   eotq_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_load;
   logic [DEPTH-1:0]                slot_used_ff, slot_used_in;
   logic [eotq_pkg::ID_W-1:0]       next_id_ff, next_id_in;
   logic [eotq_pkg::TIME_W-1:0]     last_check_ff, last_check_in;
   logic [31:0]                     interval_ff;

   eotq_pkg::cell_cmd_type          cmd;
   eotq_pkg::entry_type             ent_w [DEPTH];
   logic [SLOT_W-1:0]               slot_w [DEPTH];
   logic [DEPTH-1:0]                lt_w;
   logic [DEPTH-1:0]                hit_w;
   logic [SLOT_W-1:0]               del_slot_w [DEPTH];
   logic [DEPTH-1:0]                cell_valid;

   logic [SLOT_W-1:0]               free_idx;
   logic [SLOT_W-1:0]               found_slot;
   logic                            full;
   logic                            out_free;
   logic                            head_fire;
   logic                            next_fire;
   logic [eotq_pkg::TIME_W:0]       exp_sum;
   logic [eotq_pkg::TIME_W:0]       due_limit;
   logic                            csr_wr;

   // Row of cells.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      eotq_pkg::entry_type left_ent, right_ent;
      logic [SLOT_W-1:0]   left_slot, right_slot;
      logic                left_lt, left_hit;

      if (k == 0) begin : g_first
         assign left_ent  = '0;
         assign left_slot = '0;
         assign left_lt   = 1'b0;
         assign left_hit  = 1'b0;
      end else begin : g_mid
         assign left_ent  = ent_w[k-1];
         assign left_slot = slot_w[k-1];
         assign left_lt   = lt_w[k-1];
         assign left_hit  = hit_w[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_ent  = '0;
         assign right_slot = '0;
      end else begin : g_inner
         assign right_ent  = ent_w[k+1];
         assign right_slot = slot_w[k+1];
      end

      eotq_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_slot   (free_idx),
         .left_ent   (left_ent),
         .left_slot  (left_slot),
         .left_lt    (left_lt),
         .left_hit   (left_hit),
         .right_ent  (right_ent),
         .right_slot (right_slot),
         .ent        (ent_w[k]),
         .slot       (slot_w[k]),
         .lt         (lt_w[k]),
         .hit        (hit_w[k]),
         .del_slot   (del_slot_w[k])
      );

      assign cell_valid[k] = ent_w[k].valid;
   end

   // Lowest free slot number and the slot of the entry a delete removes.
   always_comb begin
      free_idx   = '0;
      found_slot = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         found_slot = found_slot | del_slot_w[i];
      end
   end

   assign full      = &slot_used_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_fire = ent_w[0].valid && (ent_w[0].expiry <= req_ff.now);
   assign next_fire = ent_w[1].valid && (ent_w[1].expiry <= req_ff.now);

   assign exp_sum   = {1'b0, req_ff.now} + {{(eotq_pkg::TIME_W - 31){1'b0}}, req_ff.delay};
   assign due_limit = {1'b0, last_check_ff}
                    + {{(eotq_pkg::TIME_W - 31){1'b0}}, interval_ff};

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      rsp_in        = rsp_ff;
      rsp_load      = 1'b0;
      slot_used_in  = slot_used_ff;
      next_id_in    = next_id_ff;
      last_check_in = last_check_ff;

      cmd                 = '0;
      cmd.new_ent.valid   = 1'b1;
      cmd.new_ent.expiry  = exp_ff;
      cmd.new_ent.id      = next_id_ff;
      cmd.new_ent.payload = req_ff.in_payload;
      cmd.del_id          = req_ff.del_id;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            case (req_ff.op)
               eotq_pkg::OP_ADD:    state_in = S_ADD;
               eotq_pkg::OP_DELETE: state_in = S_DEL;
               eotq_pkg::OP_TICK:   state_in = S_TICK;
               default:             state_in = S_IDLE;
            endcase
         end
         S_ADD: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (full) begin
                  rsp_in = '{eotq_pkg::ST_FULL, '0, '0, 1'b1};
               end else begin
                  cmd.ins                = 1'b1;
                  slot_used_in[free_idx] = 1'b1;
                  rsp_in     = '{eotq_pkg::ST_ADDED, next_id_ff, '0, 1'b1};
                  next_id_in = (next_id_ff == eotq_pkg::ID_MAX)
                             ? eotq_pkg::ID_W'(1) : next_id_ff + 1'b1;
               end
            end
         end
         S_DEL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               cmd.del  = 1'b1;
               if (hit_w[DEPTH-1]) begin
                  slot_used_in[found_slot] = 1'b0;
                  rsp_in = '{eotq_pkg::ST_DELETED, req_ff.del_id, '0, 1'b1};
               end else begin
                  rsp_in = '{eotq_pkg::ST_NOTFOUND, req_ff.del_id, '0, 1'b1};
               end
            end
         end
         S_TICK: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (due_ff && head_fire) begin
                  cmd.pop                 = 1'b1;
                  slot_used_in[slot_w[0]] = 1'b0;
                  rsp_in = '{eotq_pkg::ST_FIRED, ent_w[0].id, ent_w[0].payload,
                             !next_fire};
                  if (!next_fire) begin
                     state_in      = S_IDLE;
                     last_check_in = req_ff.now;
                  end
               end else begin
                  // Not due, or due with nothing expired.
                  rsp_in   = '{eotq_pkg::ST_NONE, '0, '0, 1'b1};
                  state_in = S_IDLE;
                  if (due_ff) begin
                     last_check_in = req_ff.now;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                && (csr_paddr[2] == eotq_pkg::CSR_CHECK_INTERVAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         slot_used_ff  <= '0;
         next_id_ff    <= eotq_pkg::ID_W'(1);
         last_check_ff <= '0;
         interval_ff   <= eotq_pkg::CHECK_INTERVAL_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_used_ff  <= slot_used_in;
         next_id_ff    <= next_id_in;
         last_check_ff <= last_check_in;
         if (csr_wr) begin
            interval_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (state_ff == S_PREP) begin
         exp_ff <= exp_sum[eotq_pkg::TIME_W] ? eotq_pkg::TIME_MAX
                                             : exp_sum[eotq_pkg::TIME_W-1:0];
         due_ff <= ({1'b0, req_ff.now} > due_limit);
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == eotq_pkg::CSR_CHECK_INTERVAL) ? interval_ff : '0;

`ifndef SYNTHESIS
   a_slots_match_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_used_ff) == $countones(cell_valid))
      else $error("slot map and cell row disagree on occupancy");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("occupied cells are not packed at the head of the row");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (ent_w[0].valid && ent_w[1].valid) |-> (ent_w[0].expiry <= ent_w[1].expiry))
      else $error("head of the row is not the earliest expiry");

   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("id counter reached zero");

   a_fire_removes: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> ($countones(cell_valid) == $countones($past(cell_valid)) - 1))
      else $error("firing a timer did not remove exactly one entry");
`endif

endmodule

// ----- sim/expiry_ordered_timer_queue_top_test.sv -----
// Shadow copy of the timer table. Each accepted request is applied to it at
// acceptance, and the results it must produce are queued in order.
class timer_queue_checker;
   localparam int TABLE_DEPTH = 16;

   bit                          slot_valid[TABLE_DEPTH];
   logic [eotq_pkg::TIME_W-1:0] slot_expiry[TABLE_DEPTH];
   logic [eotq_pkg::ID_W-1:0]   slot_id[TABLE_DEPTH];
   logic [eotq_pkg::DATA_W-1:0] slot_payload[TABLE_DEPTH];
   logic [eotq_pkg::ID_W-1:0]   next_id;
   logic [eotq_pkg::TIME_W-1:0] last_check;
   logic [31:0]                 check_interval;
   eotq_pkg::rsp_type           pending_results[$];
   int                          errors;
   int                          status_count[6];

   function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      foreach (status_count[i]) status_count[i] = 0;
      next_id = 1;
      last_check = '0;
      check_interval = eotq_pkg::CHECK_INTERVAL_RESET;
      errors = 0;
   endfunction

   function void queue_result(logic [2:0] status, logic [eotq_pkg::ID_W-1:0] id,
                              logic [eotq_pkg::DATA_W-1:0] payload, logic is_last);
      pending_results.insert(pending_results.size(),
                             eotq_pkg::rsp_type'{status, id, payload, is_last});
      status_count[status]++;
   endfunction

   function void note_request(eotq_pkg::req_type r);
      int                        slot;
      int                        best;
      int                        fired;
      logic [eotq_pkg::TIME_W:0] sum;
      eotq_pkg::rsp_type         tail;
      case (r.op)
         eotq_pkg::OP_ADD: begin
            slot = -1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
               if (!slot_valid[i]) slot = i;
            if (slot < 0) begin
               queue_result(eotq_pkg::ST_FULL, '0, '0, 1'b1);
            end else begin
               sum = {1'b0, r.now} + {17'b0, r.delay};
               slot_valid[slot] = 1'b1;
               slot_expiry[slot] = sum[eotq_pkg::TIME_W] ? eotq_pkg::TIME_MAX
                                                         : sum[eotq_pkg::TIME_W-1:0];
               slot_id[slot] = next_id;
               slot_payload[slot] = r.in_payload;
               queue_result(eotq_pkg::ST_ADDED, next_id, '0, 1'b1);
               next_id = (next_id == eotq_pkg::ID_MAX) ? 1 : next_id + 1;
            end
         end
         eotq_pkg::OP_DELETE: begin
            // With duplicate ids the earliest expiry goes, then the lowest slot.
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (slot_valid[i] && slot_id[i] == r.del_id &&
                   (slot < 0 || slot_expiry[i] < slot_expiry[slot]))
                  slot = i;
            if (slot < 0) begin
               queue_result(eotq_pkg::ST_NOTFOUND, r.del_id, '0, 1'b1);
            end else begin
               slot_valid[slot] = 1'b0;
               queue_result(eotq_pkg::ST_DELETED, r.del_id, '0, 1'b1);
            end
         end
         eotq_pkg::OP_TICK: begin
            fired = 0;
            if ({16'b0, r.now} > {16'b0, last_check} + {32'b0, check_interval}) begin
               do begin
                  best = -1;
                  for (int i = 0; i < TABLE_DEPTH; i++)
                     if (slot_valid[i] && slot_expiry[i] <= r.now &&
                         (best < 0 || slot_expiry[i] < slot_expiry[best] ||
                          (slot_expiry[i] == slot_expiry[best] &&
                           slot_id[i] < slot_id[best])))
                        best = i;
                  if (best >= 0) begin
                     slot_valid[best] = 1'b0;
                     queue_result(eotq_pkg::ST_FIRED, slot_id[best], slot_payload[best],
                                  1'b0);
                     fired++;
                  end
               end while (best >= 0);
               last_check = r.now;
            end
            if (fired == 0) begin
               queue_result(eotq_pkg::ST_NONE, '0, '0, 1'b1);
            end else begin
               tail = pending_results[pending_results.size() - 1];
               tail.last = 1'b1;
               pending_results[pending_results.size() - 1] = tail;
            end
         end
         default: ;
      endcase
   endfunction

   function void check_result(eotq_pkg::rsp_type got);
      eotq_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result: status %0d id %0h payload %0h last %0b",
                got.status, got.out_id, got.out_payload, got.last);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.out_id !== want.out_id) begin
         $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
         errors++;
      end
      if (got.out_payload !== want.out_payload) begin
         $error("out_payload: expected %0h, got %0h", want.out_payload, got.out_payload);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module expiry_ordered_timer_queue_top_test;

   localparam logic [1:0] OP_UNKNOWN    = 2'd3;
   localparam logic [2:0] INTERVAL_ADDR = {eotq_pkg::CSR_CHECK_INTERVAL, 2'b00};
   localparam int         TABLE_DEPTH   = 16;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   eotq_pkg::req_type req_data    = '0;
   logic              rsp_stall   = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [2:0]        csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic              req_stall;
   logic              rsp_valid;
   eotq_pkg::rsp_type rsp_data;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int                 sender_idle_pct = 0;
   int                 stall_pct       = 0;
   int                 csr_errors      = 0;
   int                 requests_sent   = 0;
   longint unsigned    sim_now;
   timer_queue_checker timer_model;

   expiry_ordered_timer_queue_top #(.DEPTH(TABLE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) timer_model.check_result(rsp_data);
   end

   // Valid stays high from one request to the next unless a gap is drawn.
   task send_request(input eotq_pkg::req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap != 0 && req_valid) begin
         req_valid <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      timer_model.note_request(r);
      requests_sent++;
   endtask

   task add_timer(input logic [eotq_pkg::TIME_W-1:0] now, input logic [31:0] delay,
                  input logic [eotq_pkg::DATA_W-1:0] payload);
      send_request(eotq_pkg::req_type'{eotq_pkg::OP_ADD, now, delay, payload,
                                       32'($urandom)});
   endtask

   task delete_timer(input logic [eotq_pkg::ID_W-1:0] id);
      send_request(eotq_pkg::req_type'{eotq_pkg::OP_DELETE,
                                       {16'($urandom), 32'($urandom)}, 32'($urandom),
                                       32'($urandom), id});
   endtask

   task tick(input logic [eotq_pkg::TIME_W-1:0] now);
      send_request(eotq_pkg::req_type'{eotq_pkg::OP_TICK, now, 32'($urandom),
                                       32'($urandom), 32'($urandom)});
   endtask

   task send_unknown();
      send_request(eotq_pkg::req_type'{OP_UNKNOWN, {16'($urandom), 32'($urandom)},
                                       32'($urandom), 32'($urandom), 32'($urandom)});
   endtask

   // Unknown ops give no result, so leave room after the last one arrives.
   task drain();
      req_valid <= 1'b0;
      while (timer_model.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task csr_access(input logic write, input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= INTERVAL_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task set_interval(input logic [31:0] value);
      logic [31:0] readback;
      drain();
      csr_access(1'b1, value, readback);
      csr_access(1'b0, '0, readback);
      if (readback !== value) begin
         $error("check_interval: expected %0h, got %0h", value, readback);
         csr_errors++;
      end
      timer_model.check_interval = value;
   endtask

   task random_phase(input int count);
      logic [31:0]               span;
      int unsigned               pick;
      logic [eotq_pkg::ID_W-1:0] live[$];
      span = (timer_model.check_interval == 0) ? 32'd1000 : timer_model.check_interval;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) begin
               add_timer({16'($urandom), 32'($urandom)}, $urandom, $urandom);
            end else begin
               sim_now += $urandom_range(0, 50);
               add_timer(eotq_pkg::TIME_W'(sim_now),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, span),
                         $urandom);
            end
         end else if (pick < 65) begin
            live.delete();
            foreach (timer_model.slot_valid[i])
               if (timer_model.slot_valid[i])
                  live.insert(live.size(), timer_model.slot_id[i]);
            if (live.size() != 0 && $urandom_range(0, 9) < 7)
               delete_timer(live[$urandom_range(0, live.size() - 1)]);
            else
               delete_timer($urandom);
         end else if (pick < 95) begin
            // Half the ticks step past the interval so that a scan is due.
            if ($urandom_range(0, 1))
               sim_now += 64'(timer_model.check_interval) + $urandom_range(1, 2000);
            else
               sim_now += $urandom_range(0, span / 8);
            tick(eotq_pkg::TIME_W'(sim_now));
         end else begin
            send_unknown();
         end
      end
   endtask

   initial begin
      logic [31:0] reset_interval;
      timer_model = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, '0, reset_interval);
      if (reset_interval !== eotq_pkg::CHECK_INTERVAL_RESET) begin
         $error("check_interval after reset: expected %0h, got %0h",
                eotq_pkg::CHECK_INTERVAL_RESET, reset_interval);
         csr_errors++;
      end

      // Directed part, interval at its reset value.
      tick(48'd0);
      add_timer(48'd100001, 32'd0, 32'hFFFF_FFFF);
      add_timer(48'd100000, 32'd1, 32'h0);
      add_timer(48'd0, 32'd100002, 32'hA5A5_5A5A);
      add_timer(eotq_pkg::TIME_MAX, 32'hFFFF_FFFF, $urandom);
      add_timer(48'h8000_0000_0000, 32'hFFFF_FFFF, $urandom);
      delete_timer(32'd5);
      delete_timer(32'd5);
      delete_timer(32'd0);
      delete_timer(eotq_pkg::ID_MAX);
      send_unknown();
      tick(48'd100000);
      tick(48'd100001);
      tick(48'd100002);
      tick(48'd200002);
      tick(48'd300003);
      sim_now = 400000;

      set_interval(eotq_pkg::CHECK_INTERVAL_RESET);
      random_phase(30);

      set_interval(32'd0);
      sender_idle_pct = 84;
      random_phase(30);

      set_interval(32'hFFFF_FFFF);
      sender_idle_pct = 0;
      stall_pct = 84;
      random_phase(30);

      set_interval($urandom_range(1, 20000));
      sender_idle_pct = 21;
      stall_pct = 21;
      random_phase(30);

      // Fill the table with tied expiries, overflow it, then fire everything.
      set_interval(32'd50);
      sender_idle_pct = 0;
      stall_pct = 84;
      repeat (TABLE_DEPTH + 1)
         add_timer(eotq_pkg::TIME_W'(sim_now),
                   ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd7, $urandom);
      tick(eotq_pkg::TIME_MAX);
      tick(eotq_pkg::TIME_MAX);
      delete_timer($urandom);
      drain();

      $display("Sent %0d requests across five interval settings, from 0 to the maximum,",
               requests_sent);
      $display("with idle and stall mixes; %0d added, %0d full, %0d deleted, %0d missed,",
               timer_model.status_count[eotq_pkg::ST_ADDED],
               timer_model.status_count[eotq_pkg::ST_FULL],
               timer_model.status_count[eotq_pkg::ST_DELETED],
               timer_model.status_count[eotq_pkg::ST_NOTFOUND]);
      $display("%0d fired, %0d idle ticks.",
               timer_model.status_count[eotq_pkg::ST_FIRED],
               timer_model.status_count[eotq_pkg::ST_NONE]);
      if (timer_model.errors == 0 && csr_errors == 0)
         $display("** expiry_ordered_timer_queue_top: PASSED **");
      else
         $display("** expiry_ordered_timer_queue_top: FAILED **");
      $finish;
   end

   initial begin
      #5000000;
      $display("Timed out with %0d results outstanding.", timer_model.pending_results.size());
      $display("** expiry_ordered_timer_queue_top: FAILED **");
      $finish;
   end

endmodule
